### design/uuencode_line_encoder_unit_assert.svh
// assertion macros for the uuencode line encoder
`ifndef UUENCODE_LINE_ENCODER_UNIT_ASSERT_SVH
`define UUENCODE_LINE_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UUENC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uuencode line encoder: check failed");

// next-cycle implication, sampled on clk, off during reset
`define UUENC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uuencode line encoder: check failed");

`endif

### design/uuenc_pkg.sv
// shared types and constants for the uuencode line encoder
package uuenc_pkg;

    localparam int MAX_GROUPS   = 15;
    localparam int GROUPS_DEF   = 15;
    localparam int CNT_W        = $clog2(MAX_GROUPS * 3 + 1);

    localparam logic [6:0] CHAR_BIAS    = 7'd32;
    localparam logic [6:0] NEWLINE_CHAR = 7'd10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       run_end;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } line_req_t;

endpackage

### design/uuenc_line_mem.sv
// line store: one write port, one read port with registered read data
module uuenc_line_mem #(
    parameter int DEPTH  = uuenc_pkg::GROUPS_DEF * 3,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/uuenc_emitter.sv
// line emitter: reads groups back from the store and drives the output register
module uuenc_emitter #(
    parameter int LINE_BYTES = uuenc_pkg::GROUPS_DEF * 3,
    parameter int ADDR_W     = $clog2(LINE_BYTES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uuenc_pkg::line_req_t req,
    output logic                 busy,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [7:0]           rd_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output uuenc_pkg::out_item_t out_item
);

    localparam int CNT_W = uuenc_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHR  = 3'd3;
    localparam logic [2:0] S_NL   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] base_reg, base_next;
    logic [1:0]       k_reg, k_next;
    logic [1:0]       slice_reg, slice_next;
    logic             keep_reg, keep_next;
    logic [23:0]      word_reg, word_next;
    logic             out_valid_reg, out_valid_next;
    uuenc_pkg::out_item_t out_item_reg, out_item_next;

    logic             can_load;
    logic             load;
    logic [CNT_W-1:0] addr_full;
    logic             addr_ok;
    logic [CNT_W:0]   base_plus;
    logic [5:0]       slice_val;

    // padded length: ceil(count/3) groups, times 3, plus bias
    function automatic logic [6:0] len_char(input logic [CNT_W-1:0] cnt);
        logic [12:0] prod;
        logic [3:0]  groups;
        prod   = (13'(cnt) + 13'd2) * 13'd43;
        groups = prod[10:7];
        return 7'({groups, 1'b0}) + 7'(groups) + uuenc_pkg::CHAR_BIAS;
    endfunction

    assign can_load  = !out_valid_reg || out_ready;
    assign addr_full = base_reg + CNT_W'(k_reg);
    assign addr_ok   = (k_reg != 2'd3) && (addr_full < count_reg);
    assign base_plus = {1'b0, base_reg} + (CNT_W + 1)'(3);

    always_comb
    begin
        case (slice_reg)
            2'd0:    slice_val = word_reg[23:18];
            2'd1:    slice_val = word_reg[17:12];
            2'd2:    slice_val = word_reg[11:6];
            default: slice_val = word_reg[5:0];
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        base_next     = base_reg;
        k_next        = k_reg;
        slice_next    = slice_reg;
        keep_next     = keep_reg;
        word_next     = word_reg;
        load          = 1'b0;
        out_item_next = out_item_reg;
        rd_en         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    count_next = req.count;
                    base_next  = '0;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (can_load)
                begin
                    load                   = 1'b1;
                    out_item_next.out_char = len_char(count_reg);
                    out_item_next.run_end  = 1'b0;
                    k_next                 = 2'd0;
                    state_next             = S_RD;
                end
            end
            S_RD:
            begin
                // issue up to three reads, capture each read's data in the next cycle
                rd_en     = addr_ok;
                keep_next = addr_ok;
                if (k_reg != 2'd0)
                begin
                    word_next = {word_reg[15:0], keep_reg ? rd_data : 8'd0};
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    slice_next = 2'd0;
                    state_next = S_CHR;
                end
            end
            S_CHR:
            begin
                if (can_load)
                begin
                    load                   = 1'b1;
                    out_item_next.out_char = {1'b0, slice_val} + uuenc_pkg::CHAR_BIAS;
                    out_item_next.run_end  = 1'b0;
                    slice_next             = slice_reg + 2'd1;
                    if (slice_reg == 2'd3)
                    begin
                        base_next = base_plus[CNT_W-1:0];
                        k_next    = 2'd0;
                        if (base_plus >= {1'b0, count_reg})
                        begin
                            state_next = S_NL;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_NL:
            begin
                if (can_load)
                begin
                    load                   = 1'b1;
                    out_item_next.out_char = uuenc_pkg::NEWLINE_CHAR;
                    out_item_next.run_end  = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= 2'd0;
            slice_reg     <= 2'd0;
            keep_reg      <= 1'b0;
            count_reg     <= '0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            slice_reg     <= slice_next;
            keep_reg      <= keep_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        out_item_reg <= out_item_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign rd_addr   = addr_full[ADDR_W-1:0];
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### design/uuencode_line_encoder_unit.sv
// uuencode line encoder top level: byte intake, line store and line emitter
// intake takes one byte per cycle while no line is being emitted
// a line of n bytes in g groups goes out as a length char, four chars per group and a newline
// (per group the emitter reads up to three bytes from the store, then emits its four chars)
// the block takes no byte while a line is emitted
// reset clears control state only; the line store is undefined until written
`include "uuencode_line_encoder_unit_assert.svh"

module uuencode_line_encoder_unit #(
    parameter int GROUPS_PER_LINE = uuenc_pkg::GROUPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  uuenc_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output uuenc_pkg::out_item_t out_item
);

    localparam int LINE_BYTES = GROUPS_PER_LINE * 3;
    localparam int ADDR_W     = $clog2(LINE_BYTES);
    localparam int CNT_W      = uuenc_pkg::CNT_W;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     count_inc;
    logic                 accept;
    logic                 line_end;
    logic                 busy;
    uuenc_pkg::line_req_t req;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [7:0]           rd_data;

    assign in_ready  = !busy;
    assign accept    = in_valid && in_ready;
    assign count_inc = count_reg + CNT_W'(1);
    assign line_end  = in_item.is_final || (count_inc == CNT_W'(LINE_BYTES));

    assign req.start = accept && line_end;
    assign req.count = count_inc;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = line_end ? '0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    uuenc_line_mem #(
        .DEPTH  (LINE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (in_item.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    uuenc_emitter #(
        .LINE_BYTES (LINE_BYTES),
        .ADDR_W     (ADDR_W)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // byte count stays inside the store whenever intake is open
    `UUENC_ASSERT_IMP(a_count_range, in_ready, count_reg < CNT_W'(LINE_BYTES))
    // a final byte closes intake on the next cycle
    `UUENC_ASSERT_NXT(a_final_closes, accept && in_item.is_final, !in_ready)
    // the end-of-line flag rides only on the newline
    `UUENC_ASSERT_IMP(a_end_is_nl, out_valid && out_item.run_end,
                      out_item.out_char == uuenc_pkg::NEWLINE_CHAR)
    // no line request while the emitter still works on a line
    `UUENC_ASSERT_IMP(a_no_overlap, busy, !req.start)

endmodule

### test/tb.sv
// testbench for the uuencode line encoder: directed and random byte streams checked per character
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BYTES  = uuenc_pkg::GROUPS_DEF * 3;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_MAX  = 10;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    uuenc_pkg::in_item_t  in_item;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    uuenc_pkg::out_item_t out_item;

    logic [7:0]           line_bytes[$];
    uuenc_pkg::out_item_t expected_chars[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_on = 1'b0;

    uuencode_line_encoder_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic uuenc_pkg::out_item_t line_char(input logic [6:0] c, input logic last);
        uuenc_pkg::out_item_t item;
        item.out_char = c;
        item.run_end  = last;
        return item;
    endfunction

    // collect one byte and queue the characters of the line it completes
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        int          groups;
        logic [23:0] word;
        line_bytes.push_back(b);
        if (fin || line_bytes.size() == LINE_BYTES)
        begin
            groups = (line_bytes.size() + 2) / 3;
            expected_chars.push_back(line_char(uuenc_pkg::CHAR_BIAS + 7'(groups * 3), 1'b0));
            for (int g = 0; g < groups; g++)
            begin
                word = '0;
                for (int k = 0; k < 3; k++)
                    if (3 * g + k < line_bytes.size())
                        word[23 - 8 * k -: 8] = line_bytes[3 * g + k];
                for (int s = 3; s >= 0; s--)
                    expected_chars.push_back(
                        line_char(uuenc_pkg::CHAR_BIAS + 7'(word[6 * s +: 6]), 1'b0));
            end
            expected_chars.push_back(line_char(uuenc_pkg::NEWLINE_CHAR, 1'b1));
            line_bytes.delete();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        uuenc_pkg::in_item_t item;
        item.data_byte = b;
        item.is_final  = fin;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        encode_byte(b, fin);
    endtask

    // random bytes, final flag on the last one, optional stray final flags
    task automatic send_line(input int len, input logic noise, inout int sent);
        logic fin;
        for (int i = 0; i < len; i++)
        begin
            fin = (i == len - 1) || (noise && $urandom_range(19) == 0);
            send_byte(8'($urandom_range(255)), fin);
            sent++;
        end
    endtask

    // line length, kept within the bytes still to send
    function automatic int pick_line_len(input int room);
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 75)
            len = $urandom_range(9, 1);
        else if (r < 93)
            len = $urandom_range(44, 10);
        else
            len = $urandom_range(50, 45);
        if (len > room)
            len = room;
        return len;
    endfunction

    task automatic test_extreme_bytes();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // padding of a short last group, store entries already written
    task automatic test_short_groups();
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // full store with and without a final flag, then a new line right after
    task automatic test_full_lines();
        int sent;
        sent = 0;
        send_line(LINE_BYTES, 1'b0, sent);
        for (int i = 0; i < LINE_BYTES; i++)
            send_byte(8'($urandom_range(255)), 1'b0);
        send_byte(8'hC3, 1'b1);
    endtask

    task automatic test_random_lines(input int items, input int idle_pct, input int stall_pct);
        int sent;
        sent = 0;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        while (sent < items)
            send_line(pick_line_len(items - sent), $urandom_range(3) == 0, sent);
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_backpressure();
        int sent;
        sent = 0;
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_on <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        while (sent < 8)
            send_line(pick_line_len(8 - sent), 1'b0, sent);
    endtask

    always @(posedge clk)
        out_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);

    task automatic note_mismatch(input uuenc_pkg::out_item_t want,
                                 input uuenc_pkg::out_item_t got, input logic none);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            if (none)
                $display("unexpected char %h end %b", got.out_char, got.run_end);
            else
                $display("expected char %h end %b, got char %h end %b",
                         want.out_char, want.run_end, got.out_char, got.run_end);
        end
    endtask

    always @(posedge clk)
    begin
        uuenc_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
                note_mismatch('0, out_item, 1'b1);
            else
            begin
                want = expected_chars.pop_front();
                if (out_item.out_char !== want.out_char || out_item.run_end !== want.run_end)
                    note_mismatch(want, out_item, 1'b0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_bytes();
        test_short_groups();
        test_full_lines();
        test_random_lines(5, 0, 0);
        test_random_lines(5, 70, 0);
        test_random_lines(5, 0, 70);
        test_random_lines(5, 24, 24);
        test_backpressure();

        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
